FILE: rtl/fsort_pkg.sv
package fsort_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } in_t;

    typedef struct packed {
        logic [15:0] value_res;
        logic        last_res;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] pos;
    } meta_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LREAD  = 8'b0000_0010,
        ST_LCMP   = 8'b0000_0100,
        ST_INSERT = 8'b0000_1000,
        ST_SREAD  = 8'b0001_0000,
        ST_SCMP   = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

endpackage

FILE: rtl/fsort_table.sv
module fsort_table import fsort_pkg::*; #(
    parameter int VB = 16
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [VB-1:0]    wvalue,
    input  meta_t            wmeta,
    input  logic [IDX_W-1:0] raddr,
    output logic [VB-1:0]    rvalue,
    output meta_t            rmeta
);

    logic [VB-1:0] value_mem [DEPTH];
    meta_t         meta_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            value_mem[waddr] <= wvalue;
            meta_mem[waddr]  <= wmeta;
        end
        rvalue <= value_mem[raddr];
        rmeta  <= meta_mem[raddr];
    end

endmodule

FILE: rtl/fsort_rank.sv
module fsort_rank import fsort_pkg::*; (
    input  meta_t a,
    input  meta_t b,
    output logic  higher
);

    // more occurrences first, then earlier first appearance
    always_comb begin
        if (a.count != b.count) higher = (a.count > b.count);
        else                    higher = (a.pos < b.pos);
    end

endmodule

FILE: rtl/frequency_sort.sv
// frequency_sort: sorts a list of values by how often each one occurs.
// Input channel s_valid/s_ready/s_data carries one value per transfer, with
// s_data.last on the final value of the list. Only the first MAX_ITEMS values
// are counted; later ones are dropped, but a marked one still ends the list.
// Each value is looked up in a 64-entry table, one entry at a time through
// a read state and a compare state; a repeated value stops at its match,
// a new one is appended after the last entry, and a dropped one is not stored.
// After the last value a single compare unit scans the table once per
// distinct value to pick the next best entry (highest count, then earliest
// first appearance), plus one final scan that finds nothing. The chosen
// entry is emitted, then written back with a zero count, and a finish state
// clears the counts. Results leave on m_valid/m_ready/m_data, each value once
// per occurrence, m_data.last_res on the final one. The output register
// holds while m_ready is low and the sequencer waits for it.
// s_ready is high only while the sequencer idles; the next list may start
// while the final result still waits. Reset (aresetn low, synchronous)
// empties the table at once through its fill count; no clearing pass.
module frequency_sort import fsort_pkg::*; #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] items_reg, items_next;
    logic [CNT_W-1:0] produced_reg, produced_next;
    logic [CNT_W-1:0] rep_reg, rep_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             best_valid_reg, best_valid_next;
    logic [VALUE_BITS-1:0] best_value_reg, best_value_next;
    meta_t            best_meta_reg, best_meta_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [VALUE_BITS-1:0] wvalue;
    meta_t                 wmeta;
    logic [VALUE_BITS-1:0] rvalue;
    meta_t                 rmeta;
    logic                  higher;
    logic                  take;
    logic                  at_end;
    logic                  can_load;
    logic [47:0]           in_wide;
    logic [47:0]           out_wide;

    fsort_table #(.VB(VALUE_BITS)) u_table (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wvalue (wvalue),
        .wmeta  (wmeta),
        .raddr  (idx_reg),
        .rvalue (rvalue),
        .rmeta  (rmeta)
    );

    fsort_rank u_rank (
        .a      (rmeta),
        .b      (best_meta_reg),
        .higher (higher)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign in_wide  = {32'd0, s_data.value};
    assign out_wide = 48'(best_value_reg);
    assign at_end   = ({1'b0, idx_reg} + 1'b1) == total_reg;
    assign take     = (rmeta.count != '0) && (!best_valid_reg || higher);
    assign can_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        total_next      = total_reg;
        items_next      = items_reg;
        produced_next   = produced_reg;
        rep_next        = rep_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_valid_next = best_valid_reg;
        best_value_next = best_value_reg;
        best_meta_next  = best_meta_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wvalue          = val_reg;
        wmeta           = rmeta;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next  = in_wide[VALUE_BITS-1:0];
                    last_next = s_data.last;
                    idx_next  = '0;
                    best_valid_next = 1'b0;
                    if (items_reg < MAX_C) begin
                        state_next = (total_reg == '0) ? ST_INSERT : ST_LREAD;
                    end else if (s_data.last) begin
                        state_next = ST_SREAD;
                    end
                end
            end
            ST_LREAD: state_next = ST_LCMP;
            ST_LCMP: begin
                if (rvalue == val_reg) begin
                    we          = 1'b1;
                    wvalue      = rvalue;
                    wmeta.count = rmeta.count + 1'b1;
                    items_next  = items_reg + 1'b1;
                    idx_next    = '0;
                    state_next  = last_reg ? ST_SREAD : ST_IDLE;
                end else if (at_end) begin
                    state_next = ST_INSERT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LREAD;
                end
            end
            ST_INSERT: begin
                we          = 1'b1;
                waddr       = total_reg[IDX_W-1:0];
                wmeta.count = CNT_W'(1);
                wmeta.pos   = items_reg[IDX_W-1:0];
                total_next  = total_reg + 1'b1;
                items_next  = items_reg + 1'b1;
                idx_next    = '0;
                state_next  = last_reg ? ST_SREAD : ST_IDLE;
            end
            ST_SREAD: state_next = ST_SCMP;
            ST_SCMP: begin
                if (take) begin
                    best_valid_next = 1'b1;
                    best_idx_next   = idx_reg;
                    best_value_next = rvalue;
                    best_meta_next  = rmeta;
                end
                if (at_end) begin
                    rep_next   = '0;
                    state_next = (best_valid_reg || take) ? ST_EMIT : ST_FINISH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SREAD;
                end
            end
            ST_EMIT: begin
                if (rep_reg == best_meta_reg.count) begin
                    // entry done: a zero count marks it as already emitted
                    we              = 1'b1;
                    waddr           = best_idx_reg;
                    wvalue          = best_value_reg;
                    wmeta           = best_meta_reg;
                    wmeta.count     = '0;
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    state_next      = ST_SREAD;
                end else if (can_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.value_res = out_wide[15:0];
                    m_data_next.last_res = (produced_reg + 1'b1) == items_reg;
                    rep_next             = rep_reg + 1'b1;
                    produced_next        = produced_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                total_next    = '0;
                items_next    = '0;
                produced_next = '0;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            items_reg    <= '0;
            produced_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            items_reg    <= items_next;
            produced_reg <= produced_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_reg        <= rep_next;
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_valid_reg <= best_valid_next;
        best_value_reg <= best_value_next;
        best_meta_reg  <= best_meta_next;
        val_reg        <= val_next;
        last_reg       <= last_next;
        m_data_reg     <= m_data_next;
    end

    a_total_le_items: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= items_reg)
        else $error("distinct count exceeds item count");

    a_produced_le_items: assert property (@(posedge aclk) disable iff (!aresetn)
        produced_reg <= items_reg)
        else $error("more results than stored items");

    a_finish_all_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> produced_reg == items_reg)
        else $error("list finished with results missing");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && items_reg < MAX_C |=> state_reg != ST_IDLE)
        else $error("stored transfer did not start a lookup");

endmodule
